[rtl/pbds_pkg.sv]
// Shared types and constants for the paletted 2x2 box downsampler.
package pbds_pkg;

  // Input word function codes.
  typedef enum logic [1:0] {
    FUNC_PIXEL     = 2'd0,
    FUNC_COLOUR_WR = 2'd1,
    FUNC_INV_WR    = 2'd2,
    FUNC_UNUSED    = 2'd3
  } func_t;

  // What a pixel does once its colour term is known.
  typedef enum logic [1:0] {
    KIND_LEFT = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_EMIT = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int unsigned CFG_W_BITS = 11;
  localparam int unsigned CFG_H_BITS = 13;
  localparam int unsigned ROW_BITS   = 12;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd200;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_MAX   = 13'd4096;

  localparam int unsigned COLOUR_DEPTH = 256;
  localparam int unsigned INV_DEPTH    = 32768;
  localparam int unsigned INV_AW       = 15;

  // Keeps three 8-bit colour fields at bits 0, 11 and 22 with guard bits above.
  localparam logic [31:0] FIELD_MASK = 32'h3fc7f8ff;

  // Colour word to guarded term.
  function automatic logic [31:0] term_of(input logic [31:0] colour);
    term_of = (colour >> 2) & FIELD_MASK;
  endfunction

  // Top five bits of each 10-bit field sum form the inverse table address.
  function automatic logic [INV_AW-1:0] inv_index(input logic [31:0] sum);
    inv_index = {sum[31:27], sum[20:16], sum[9:5]};
  endfunction

endpackage

[rtl/pbds_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pbds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/paletted_box_downsample_2x2_core.sv]
// Top level of the paletted 2x2 box downsampler.
// A block result passes stage 1, stage 2 and the output register after its last word is accepted.
// Throughput: one input word per cycle unless stage 1 stalls; the colour, line and inverse RAMs each take one access
// per port per cycle, and the output register holds a result while new words keep coming.
// Reset (synchronous, active low) clears counters, pipeline valids and the left term and loads
// width 320 and height 200; table and line RAM contents are undefined until written.
module paletted_box_downsample_2x2_core
  import pbds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input words.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_pixel_index,
  input  logic [14:0]           in_table_address,
  input  logic [31:0]           in_table_data,
  // Result words.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel,
  output logic                  out_end_of_row,
  output logic                  out_end_of_frame,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_H_BITS-1:0] cfg_data
);

  localparam int unsigned CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned UW         = (CW + 1 > CFG_W_BITS) ? CW + 1 : CFG_W_BITS;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned SW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned WIDTH_LIM  = MAX_WIDTH - (MAX_WIDTH % 2);

  // Configuration registers.
  logic [CFG_W_BITS-1:0] cfg_w_r;
  logic [CFG_H_BITS-1:0] cfg_h_r;

  // Pixel counters.
  logic [CW-1:0]       col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;

  // Stage 1: colour and line store reads in flight.
  logic          s1_v_r;
  kind_t         s1_kind_r;
  logic [SW-1:0] s1_slot_r;
  logic          s1_eor_r, s1_eof_r;

  // Stage 2: inverse table read in flight.
  logic s2_v_r, s2_eor_r, s2_eof_r;

  // Output register.
  logic       out_v_r, out_eor_r, out_eof_r;
  logic [7:0] out_pix_r;

  logic [31:0] left_term_r;

  logic [UW-1:0]         used_w, col_ext, col_eff;
  logic [CFG_H_BITS-1:0] used_h, row_ext, row_eff;
  logic                  last_col, last_row;
  logic                  in_acc, px_acc, s1_ld, s1_go, s2_ld, s2_free, out_ld;
  kind_t                 kind_in;
  logic [31:0]           col_rdata, line_rdata, term, pair_sum, blk_sum;
  logic [7:0]            inv_rdata;
  logic                  line_we, colour_we, inv_we;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= WIDTH_RESET;
      cfg_h_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) begin
        cfg_w_r <= cfg_data[CFG_W_BITS-1:0];
      end else begin
        cfg_h_r <= cfg_data;
      end
    end
  end

  // Even sizes clamped to the supported range.
  always_comb begin
    used_w = UW'(cfg_w_r) & ~UW'(1);
    if (used_w < UW'(2)) begin
      used_w = UW'(2);
    end
    if (used_w > UW'(WIDTH_LIM)) begin
      used_w = UW'(WIDTH_LIM);
    end
    used_h = cfg_h_r & ~CFG_H_BITS'(1);
    if (used_h < CFG_H_BITS'(2)) begin
      used_h = CFG_H_BITS'(2);
    end
    if (used_h > HEIGHT_MAX) begin
      used_h = HEIGHT_MAX;
    end
  end

  // Position of the incoming pixel; counters past the end are pulled back to it.
  always_comb begin
    col_ext  = UW'(col_r);
    row_ext  = CFG_H_BITS'(row_r);
    col_eff  = (col_ext >= used_w) ? used_w - UW'(1) : col_ext;
    row_eff  = (row_ext >= used_h) ? used_h - CFG_H_BITS'(1) : row_ext;
    last_col = (col_eff == used_w - UW'(1));
    last_row = (row_eff == used_h - CFG_H_BITS'(1));
    if (!col_eff[0]) begin
      kind_in = KIND_LEFT;
    end else if (!row_eff[0]) begin
      kind_in = KIND_PAIR;
    end else begin
      kind_in = KIND_EMIT;
    end
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : ROW_BITS'(row_eff + CFG_H_BITS'(1));
    end else begin
      col_nxt = CW'(col_eff + UW'(1));
      row_nxt = ROW_BITS'(row_eff);
    end
  end

  // Pipeline flow: a stage moves when the one after it is free or moving.
  assign out_ld   = s2_v_r && (!out_v_r || out_ready);
  assign s2_free  = !s2_v_r || out_ld;
  assign s1_go    = s1_v_r && ((s1_kind_r != KIND_EMIT) || s2_free);
  assign s2_ld    = s1_go && (s1_kind_r == KIND_EMIT);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;
  assign px_acc   = in_acc && (in_func == FUNC_PIXEL);
  assign s1_ld    = px_acc;

  assign colour_we = in_acc && (in_func == FUNC_COLOUR_WR);
  assign inv_we    = in_acc && (in_func == FUNC_INV_WR);

  // Counters advance on pixel words only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (px_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ld) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_kind_r <= kind_in;
      s1_slot_r <= SW'(col_eff >> 1);
      s1_eor_r  <= last_col;
      s1_eof_r  <= last_col && last_row;
    end
  end

  // Colour table: written by table words, read by each accepted pixel.
  pbds_ram #(
    .WIDTH(32),
    .DEPTH(COLOUR_DEPTH)
  ) u_colour_ram (
    .clk  (clk),
    .we   (colour_we),
    .waddr(in_table_address[7:0]),
    .wdata(in_table_data),
    .re   (s1_ld),
    .raddr(in_pixel_index),
    .rdata(col_rdata)
  );

  // Term arithmetic. A pair is written one row before it is read, so the
  // read of a slot by a block pixel never meets its write in the same cycle.
  assign term     = term_of(col_rdata);
  assign pair_sum = left_term_r + term;
  assign blk_sum  = line_rdata + pair_sum;
  assign line_we  = s1_go && (s1_kind_r == KIND_PAIR);

  // Line store of horizontal pair sums from the even row.
  pbds_ram #(
    .WIDTH(32),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(s1_slot_r),
    .wdata(pair_sum),
    .re   (s1_ld),
    .raddr(SW'(col_eff >> 1)),
    .rdata(line_rdata)
  );

  // Left pixel term of the current pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_term_r <= '0;
    end else if (s1_go && (s1_kind_r == KIND_LEFT)) begin
      left_term_r <= term;
    end
  end

  // Inverse table maps the block sum back to a palette index.
  pbds_ram #(
    .WIDTH(8),
    .DEPTH(INV_DEPTH)
  ) u_inv_ram (
    .clk  (clk),
    .we   (inv_we),
    .waddr(in_table_address),
    .wdata(in_table_data[7:0]),
    .re   (s2_ld),
    .raddr(inv_index(blk_sum)),
    .rdata(inv_rdata)
  );

  // Stage 2 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ld) begin
      s2_v_r <= 1'b1;
    end else if (out_ld) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_eor_r <= s1_eor_r;
      s2_eof_r <= s1_eof_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_pix_r <= inv_rdata;
      out_eor_r <= s2_eor_r;
      out_eof_r <= s2_eof_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pixel        = out_pix_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // The last word of the image also closes its row.
  a_eof_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_eof_r |-> out_eor_r)
    else $error("end of frame without end of row");

  // After a pixel the counters lie inside the image.
  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(px_acc) && !$past(cfg_valid) |-> (UW'(col_r) < used_w) &&
    (CFG_H_BITS'(row_r) < used_h))
    else $error("pixel counter beyond image size");

  // A stalled stage 1 keeps its colour and line read data.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(col_rdata) && $stable(line_rdata))
    else $error("stage 1 read data lost while stalled");

  // A stalled stage 2 keeps its inverse table result.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_ld |=> s2_v_r && $stable(inv_rdata))
    else $error("stage 2 read data lost while stalled");

endmodule

[bench/tb.sv]
// Self-checking bench for the paletted 2x2 box downsampler core.
`timescale 1ns / 1ps

module tb
  import pbds_pkg::*;
();

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 4096;
  localparam int PAIR_DEPTH     = MAX_W / 2;
  localparam int FILL_W         = 64;
  localparam int PAL_SIZE       = 8;
  localparam int RANDOM_PIXELS  = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 600000;

  // One input word as queued for the driver.
  typedef struct {
    func_t       func;
    logic [7:0]  pix;
    logic [14:0] addr;
    logic [31:0] data;
  } in_word_t;

  // One filtered 2x2 block as it should leave the core.
  typedef struct {
    logic [7:0] pixel;
    logic       eor;
    logic       eof;
  } block_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = 2'd0;
  logic [7:0]            in_pixel_index = 8'd0;
  logic [14:0]           in_table_address = 15'd0;
  logic [31:0]           in_table_data = 32'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_pixel;
  logic                  out_end_of_row;
  logic                  out_end_of_frame;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = 1'b0;
  logic [CFG_H_BITS-1:0] cfg_data = '0;

  // Bench-side copy of the core state.
  logic [31:0] colour_mem [COLOUR_DEPTH];
  logic [7:0]  inverse_mem [INV_DEPTH];
  logic [31:0] pair_mem [PAIR_DEPTH];
  logic [31:0] left_sum = 32'd0;
  int          col_cnt = 0;
  int          row_cnt = 0;
  int          cur_width = int'(WIDTH_RESET);
  int          cur_height = int'(HEIGHT_RESET);

  // Palette indices that pixels draw from; their colour entries are loaded first.
  logic [7:0]  pal [PAL_SIZE];

  in_word_t      word_q[$];
  in_word_t      held;
  block_result_t filtered_q[$];
  logic          steady = 1'b0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            pixels_sent = 0;

  paletted_box_downsample_2x2_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pixel_index   (in_pixel_index),
    .in_table_address (in_table_address),
    .in_table_data    (in_table_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Width register as the core uses it: even and clamped to the line store.
  function automatic int width_in_use(input int reg_w);
    int w;
    w = reg_w & ~1;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  // Height register as the core uses it: even and clamped to the row range.
  function automatic int height_in_use(input int reg_h);
    int h;
    h = reg_h & ~1;
    if (h < 2) h = 2;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // A pixel index taken from the loaded palette.
  function automatic logic [7:0] pick_pix();
    return pal[$urandom_range(PAL_SIZE - 1)];
  endfunction

  // A random table address.
  function automatic logic [14:0] rand_addr();
    return 15'($urandom_range(32767));
  endfunction

  // Colour word whose three fields are each all zeros or all ones, so every block
  // sum lands on one of a few inverse table entries; the bits between fields are random.
  function automatic logic [31:0] make_colour();
    logic [31:0] c;
    c = $urandom();
    c[9:2]   = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
    c[20:13] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
    c[31:24] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
    return c;
  endfunction

  // Top five bits of a field sum of k full-scale terms.
  function automatic logic [4:0] level(input int k);
    return 5'((k * 255) >> 5);
  endfunction

  // Advance the bench state by one accepted word and queue any block result.
  task automatic absorb_word(input in_word_t wd);
    int            w;
    int            h;
    int            slot;
    logic [31:0]   term;
    logic [31:0]   sum;
    logic          last_col;
    logic          last_row;
    block_result_t res;
    case (wd.func)
      FUNC_COLOUR_WR: colour_mem[wd.addr[7:0]] = wd.data;
      FUNC_INV_WR:    inverse_mem[wd.addr] = wd.data[7:0];
      FUNC_PIXEL: begin
        w = width_in_use(cur_width);
        h = height_in_use(cur_height);
        // Counters left beyond a shrunken size snap to the last position.
        if (col_cnt >= w) col_cnt = w - 1;
        if (row_cnt >= h) row_cnt = h - 1;
        term = (colour_mem[wd.pix] >> 2) & FIELD_MASK;
        slot = col_cnt >> 1;
        if (slot >= PAIR_DEPTH) slot = PAIR_DEPTH - 1;
        last_col = (col_cnt >= w - 1);
        last_row = (row_cnt >= h - 1);
        if ((col_cnt & 1) == 0) begin
          left_sum = term;
        end else if ((row_cnt & 1) == 0) begin
          pair_mem[slot] = left_sum + term;
        end else begin
          sum = pair_mem[slot] + left_sum + term;
          res.pixel = inverse_mem[{sum[31:27], sum[20:16], sum[9:5]}];
          res.eor = last_col;
          res.eof = last_col && last_row;
          filtered_q.push_back(res);
        end
        if (last_col) begin
          col_cnt = 0;
          row_cnt = last_row ? 0 : row_cnt + 1;
        end else begin
          col_cnt = col_cnt + 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_word(input func_t f, input logic [7:0] p, input logic [14:0] a,
                           input logic [31:0] d);
    in_word_t wd;
    wd.func = f;
    wd.pix = p;
    wd.addr = a;
    wd.data = d;
    word_q.push_back(wd);
  endtask

  // Pixels from the palette, mixed with table writes and unused-code noise.
  task automatic push_mixed(input int count);
    int n;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_word(FUNC_COLOUR_WR, pick_pix(), rand_addr(), make_colour());
      end else if (r < 10) begin
        push_word(FUNC_INV_WR, pick_pix(), rand_addr(), $urandom());
      end else if (r < 14) begin
        push_word(FUNC_UNUSED, pick_pix(), rand_addr(), $urandom());
      end else begin
        push_word(FUNC_PIXEL, pick_pix(), rand_addr(), $urandom());
        n++;
        pixels_sent++;
      end
    end
  endtask

  // Hold off until every word is in and every block result is out.
  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || filtered_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_H_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) cur_width = value & 'h7ff;
    else cur_height = value & 'h1fff;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Input driver: presents queued words, idling at random unless steady.
  always @(posedge clk) begin : drive_words
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(held);
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          held = word_q.pop_front();
          in_valid <= 1'b1;
          in_func <= held.func;
          in_pixel_index <= held.pix;
          in_table_address <= held.addr;
          in_table_data <= held.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted word with the oldest expected block.
  always @(posedge clk) begin : check_results
    block_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result word: out_pixel %0d", out_pixel);
          mismatch_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_pixel !== want.pixel) begin
            $error("out_pixel: expected %0d, got %0d", want.pixel, out_pixel);
            mismatch_count++;
          end
          if (out_end_of_row !== want.eor) begin
            $error("out_end_of_row: expected %0d, got %0d", want.eor, out_end_of_row);
            mismatch_count++;
          end
          if (out_end_of_frame !== want.eof) begin
            $error("out_end_of_frame: expected %0d, got %0d", want.eof, out_end_of_frame);
            mismatch_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          seg;
    int          w_val;
    int          h_val;
    int          frame_px;
    int          r;
    logic [31:0] colour;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Palette with both extreme indices.
    for (int i = 0; i < PAL_SIZE; i++) pal[i] = 8'($urandom_range(255));
    pal[0] = 8'h00;
    pal[PAL_SIZE-1] = 8'hff;

    // Load the palette colours and every inverse entry that a block sum can reach.
    write_reg(CFG_WIDTH, FILL_W);
    write_reg(CFG_HEIGHT, 2);
    for (int i = 0; i < PAL_SIZE; i++) begin
      if (pal[i] == 8'h00) colour = 32'h0;
      else if (pal[i] == 8'hff) colour = 32'hffffffff;
      else colour = make_colour();
      push_word(FUNC_COLOUR_WR, pick_pix(), {7'($urandom_range(127)), pal[i]}, colour);
    end
    for (int i2 = 0; i2 < 5; i2++) begin
      for (int i1 = 0; i1 < 5; i1++) begin
        for (int i0 = 0; i0 < 5; i0++) begin
          push_word(FUNC_INV_WR, pick_pix(), {level(i2), level(i1), level(i0)}, $urandom());
        end
      end
    end
    // A frame with no idling fills every line store slot that later widths can reach.
    steady = 1'b1;
    for (int i = 0; i < 2 * FILL_W; i++) begin
      push_word(FUNC_PIXEL, pick_pix(), rand_addr(), $urandom());
    end
    wait_idle();
    steady = 1'b0;

    // Smallest frame: extreme field values, every function code, writes inside a block.
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    push_word(FUNC_PIXEL, 8'h00, 15'h0000, 32'h00000000);
    push_word(FUNC_COLOUR_WR, 8'hff, 15'h7fff, 32'hffffffff);
    push_word(FUNC_UNUSED, 8'hff, 15'h7fff, 32'hffffffff);
    push_word(FUNC_PIXEL, 8'hff, 15'h7fff, 32'hffffffff);
    push_word(FUNC_INV_WR, 8'h00, 15'h7fff, 32'hffffffff);
    push_word(FUNC_PIXEL, 8'hff, 15'h0000, 32'h00000000);
    push_word(FUNC_PIXEL, 8'hff, 15'h7fff, 32'h00000000);
    wait_idle();

    // Shrink the width and then the height while a frame is under way.
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 4);
    for (int i = 0; i < 6; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();
    write_reg(CFG_WIDTH, 2);
    for (int i = 0; i < 3; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();
    write_reg(CFG_HEIGHT, 2);
    for (int i = 0; i < 4; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();

    // Odd, zero and oversized register values.
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 5);
    for (int i = 0; i < 2; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    for (int i = 0; i < 2; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();
    write_reg(CFG_WIDTH, 'h1fff);
    write_reg(CFG_HEIGHT, 'h1fff);
    for (int i = 0; i < 2; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);
    wait_idle();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 1);
    for (int i = 0; i < 2; i++) push_word(FUNC_PIXEL, pick_pix(), 15'h0, 32'h0);

    // Random segments: mostly whole small frames, some partial ones and size changes.
    seg = 0;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      if (seg == 0 || $urandom_range(99) < 70) begin
        r = $urandom_range(99);
        if (r < 65) w_val = 2 * $urandom_range(1, 8);
        else if (r < 90) w_val = $urandom_range(0, FILL_W);
        else w_val = FILL_W + 2048 * $urandom_range(0, 3);
        r = $urandom_range(99);
        if (r < 70) h_val = 2 * $urandom_range(1, 4);
        else if (r < 90) h_val = $urandom_range(0, 9);
        else h_val = $urandom_range(0, 8191);
        wait_idle();
        write_reg(CFG_WIDTH, w_val);
        write_reg(CFG_HEIGHT, h_val);
      end
      frame_px = width_in_use(cur_width) * height_in_use(cur_height);
      if (seg == 4) steady = 1'b1;
      if (frame_px <= 160 && $urandom_range(99) < 80) push_mixed(frame_px);
      else push_mixed($urandom_range(1, 120));
      if (seg == 4) begin
        wait_idle();
        steady = 1'b0;
      end
      seg++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pbds_pkg.sv
rtl/pbds_ram.sv
rtl/paletted_box_downsample_2x2_core.sv
bench/tb.sv
